FILE: sv/acr_pkg.sv
// Shared types, command and reply codes, and helpers for the adapter command responder.
`default_nettype none

package acr_pkg;

    // Command bytes recognised in the idle phase.
    localparam logic [7:0] CMD_STATUS  = 8'h01;
    localparam logic [7:0] CMD_PING    = 8'h05;
    localparam logic [7:0] CMD_INIT    = 8'h1E;
    localparam logic [7:0] CMD_SETUP_A = 8'h81;
    localparam logic [7:0] CMD_SETUP_B = 8'h82;
    localparam logic [7:0] CMD_START   = 8'h83;
    localparam logic [7:0] CMD_PACKET  = 8'h84;
    localparam logic [7:0] CMD_CHANNEL = 8'h85;

    // Reply bytes sent back on the link.
    localparam logic [7:0] RPL_NO_CHAN  = 8'h9F;
    localparam logic [7:0] RPL_CHAN_OK  = 8'h1F;
    localparam logic [7:0] RPL_ACK      = 8'h10;
    localparam logic [7:0] RPL_DONE     = 8'hE1;
    localparam logic [7:0] RPL_CONFIRM  = 8'h06;
    localparam logic [7:0] RPL_FINISHED = 8'hE4;

    // Most results that one input item can cause.
    localparam int MAX_RESULTS = 3;

    // Protocol phase, one-hot.
    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_CH0  = 7'b0000010,
        PH_CH1  = 7'b0000100,
        PH_RQ0  = 7'b0001000,
        PH_RQ1  = 7'b0010000,
        PH_RQ2  = 7'b0100000,
        PH_RQ3  = 7'b1000000
    } phase_t;

    // One result item, less the fields shared by all results of an input.
    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        request_valid;
        logic [31:0] request_word;
    } res_t;

    // Responder state kept between input items.
    typedef struct packed {
        phase_t      phase;
        logic [15:0] channel;
        logic        channel_ok;
        logic [31:0] request_acc;
    } core_state_t;

    // The results caused by one input item, waiting to be sent.
    typedef struct packed {
        res_t [MAX_RESULTS-1:0] slot;
        logic [1:0]             count;
        logic [15:0]            channel;
        logic                   channel_ok;
    } burst_t;

    // A reply byte result.
    function automatic res_t tx_res(input logic [7:0] b);
        res_t r;
        r.tx_valid      = 1'b1;
        r.tx_byte       = b;
        r.request_valid = 1'b0;
        r.request_word  = 32'h0;
        return r;
    endfunction

    // A request word result.
    function automatic res_t req_res(input logic [31:0] w);
        res_t r;
        r.tx_valid      = 1'b0;
        r.tx_byte       = 8'h00;
        r.request_valid = 1'b1;
        r.request_word  = w;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/adapter_command_responder_top.sv
// Top level of the adapter command responder: state, result buffer and channel handshakes.
//
//  Channel  Direction  Handshake            Payload
//  in       receive    in_valid / in_stall  rx_byte, rx_error
//  out      send       out_valid / out_stall tx_valid, tx_byte, request_valid, request_word,
//                                           channel_code, channel_ok, last
//
// An item is decoded in the cycle it is accepted; its zero to three results are held in a
// result buffer and leave one per cycle while the output does not stall, since the result
// buffer has a single output port.
// A new item is taken in the cycle the last buffered result leaves.
// Reset puts the phase to idle, clears the channel code and sets its valid flag.
// A stall on the output holds the current result and, once the buffer is busy, the input.
`default_nettype none

module adapter_command_responder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        rx_error,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             tx_valid,
    output logic [7:0]       tx_byte,
    output logic             request_valid,
    output logic [31:0]      request_word,
    output logic [15:0]      channel_code,
    output logic             channel_ok,
    output logic             last
);

    acr_pkg::core_state_t state_reg;
    acr_pkg::core_state_t state_next;
    acr_pkg::burst_t      burst_next;

    acr_pkg::res_t [acr_pkg::MAX_RESULTS-1:0] slot_reg;
    logic [1:0]                               count_reg;
    logic [1:0]                               idx_reg;
    logic [15:0]                              channel_reg;
    logic                                     channel_ok_reg;

    logic          take;
    logic          last_take;
    logic          accept;
    logic          is_last;
    acr_pkg::res_t cur_res;

    acr_decode u_decode (
        .cur      (state_reg),
        .rx_byte  (rx_byte),
        .rx_error (rx_error),
        .nxt      (state_next),
        .burst    (burst_next)
    );

    // Handshake decisions.
    always_comb
    begin
        out_valid = (count_reg != 2'd0);
        is_last   = (idx_reg == (count_reg - 2'd1));
        take      = out_valid && !out_stall;
        last_take = take && is_last;
        in_stall  = out_valid && !last_take;
        accept    = in_valid && !in_stall;
    end

    // Responder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= acr_pkg::PH_IDLE;
            state_reg.channel     <= 16'h0000;
            state_reg.channel_ok  <= 1'b1;
            state_reg.request_acc <= 32'h0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Result buffer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else if (accept)
        begin
            count_reg <= burst_next.count;
            idx_reg   <= 2'd0;
        end
        else if (last_take)
        begin
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Result buffer payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg       <= burst_next.slot;
            channel_reg    <= burst_next.channel;
            channel_ok_reg <= burst_next.channel_ok;
        end
    end

    // Present the current result item.
    always_comb
    begin
        cur_res       = slot_reg[idx_reg];
        tx_valid      = cur_res.tx_valid;
        tx_byte       = cur_res.tx_byte;
        request_valid = cur_res.request_valid;
        request_word  = cur_res.request_word;
        channel_code  = channel_reg;
        channel_ok    = channel_ok_reg;
        last          = is_last;
    end

endmodule

`default_nettype wire

FILE: sv/acr_decode.sv
// Next-state and result decoding for one received byte of the responder.
`default_nettype none

module acr_decode (
    input  wire acr_pkg::core_state_t cur,
    input  wire logic [7:0]      rx_byte,
    input  wire logic            rx_error,
    output acr_pkg::core_state_t nxt,
    output acr_pkg::burst_t      burst
);

    acr_pkg::res_t [acr_pkg::MAX_RESULTS-1:0] slot;
    logic [1:0]                               count;

    // Phase handling and reply selection.
    always_comb
    begin
        nxt   = cur;
        slot  = '0;
        count = 2'd0;
        case (cur.phase)
            acr_pkg::PH_CH0:
            begin
                if (rx_error)
                begin
                    nxt.channel    = 16'h0000;
                    nxt.channel_ok = 1'b0;
                    nxt.phase      = acr_pkg::PH_IDLE;
                end
                else
                begin
                    nxt.channel = {8'h00, rx_byte};
                    nxt.phase   = acr_pkg::PH_CH1;
                end
            end
            acr_pkg::PH_CH1:
            begin
                if (rx_error)
                begin
                    nxt.channel    = 16'h0000;
                    nxt.channel_ok = 1'b0;
                end
                else
                begin
                    nxt.channel    = {cur.channel[15:8] | rx_byte, cur.channel[7:0]};
                    nxt.channel_ok = 1'b1;
                    slot[0]        = acr_pkg::tx_res(acr_pkg::RPL_FINISHED);
                    count          = 2'd1;
                end
                nxt.phase = acr_pkg::PH_IDLE;
            end
            acr_pkg::PH_RQ0:
            begin
                if (rx_error)
                begin
                    nxt.request_acc = 32'h0;
                    nxt.phase       = acr_pkg::PH_IDLE;
                end
                else
                begin
                    nxt.request_acc = cur.request_acc | {24'h0, rx_byte};
                    nxt.phase       = acr_pkg::PH_RQ1;
                end
            end
            acr_pkg::PH_RQ1:
            begin
                if (rx_error)
                begin
                    nxt.request_acc = 32'h0;
                    nxt.phase       = acr_pkg::PH_IDLE;
                end
                else
                begin
                    nxt.request_acc = cur.request_acc | {16'h0, rx_byte, 8'h00};
                    nxt.phase       = acr_pkg::PH_RQ2;
                end
            end
            acr_pkg::PH_RQ2:
            begin
                if (rx_error)
                begin
                    nxt.request_acc = 32'h0;
                    nxt.phase       = acr_pkg::PH_IDLE;
                end
                else
                begin
                    nxt.request_acc = cur.request_acc | {8'h00, rx_byte, 16'h0};
                    nxt.phase       = acr_pkg::PH_RQ3;
                end
            end
            acr_pkg::PH_RQ3:
            begin
                if (!rx_error)
                begin
                    slot[0] = acr_pkg::tx_res(acr_pkg::RPL_FINISHED);
                    slot[1] = acr_pkg::req_res(cur.request_acc | {rx_byte, 24'h0});
                    count   = 2'd2;
                end
                nxt.request_acc = 32'h0;
                nxt.phase       = acr_pkg::PH_IDLE;
            end
            default:
            begin
                // Idle, and any code that is not a legal phase.
                nxt.phase = acr_pkg::PH_IDLE;
                if (!rx_error)
                begin
                    case (rx_byte)
                        acr_pkg::CMD_STATUS:
                        begin
                            slot[0] = acr_pkg::tx_res(cur.channel_ok ? acr_pkg::RPL_CHAN_OK
                                                                     : acr_pkg::RPL_NO_CHAN);
                            slot[1] = acr_pkg::tx_res(acr_pkg::RPL_ACK);
                            slot[2] = acr_pkg::tx_res(acr_pkg::RPL_DONE);
                            count   = 2'd3;
                        end
                        acr_pkg::CMD_PING:
                        begin
                            slot[0] = acr_pkg::tx_res(acr_pkg::RPL_FINISHED);
                            count   = 2'd1;
                        end
                        acr_pkg::CMD_INIT:
                        begin
                            slot[0] = acr_pkg::tx_res(acr_pkg::RPL_ACK);
                            slot[1] = acr_pkg::tx_res(acr_pkg::RPL_DONE);
                            count   = 2'd2;
                        end
                        acr_pkg::CMD_SETUP_A, acr_pkg::CMD_SETUP_B:
                        begin
                            slot[0] = acr_pkg::tx_res(acr_pkg::RPL_ACK);
                            slot[1] = acr_pkg::tx_res(acr_pkg::RPL_CONFIRM);
                            count   = 2'd2;
                        end
                        acr_pkg::CMD_START:
                        begin
                            slot[0] = acr_pkg::tx_res(acr_pkg::RPL_ACK);
                            slot[1] = acr_pkg::tx_res(acr_pkg::RPL_CONFIRM);
                            slot[2] = acr_pkg::tx_res(acr_pkg::RPL_FINISHED);
                            count   = 2'd3;
                        end
                        acr_pkg::CMD_PACKET:
                        begin
                            slot[0]         = acr_pkg::tx_res(acr_pkg::RPL_ACK);
                            slot[1]         = acr_pkg::tx_res(acr_pkg::RPL_CONFIRM);
                            count           = 2'd2;
                            nxt.request_acc = 32'h0;
                            nxt.phase       = acr_pkg::PH_RQ0;
                        end
                        acr_pkg::CMD_CHANNEL:
                        begin
                            slot[0]   = acr_pkg::tx_res(acr_pkg::RPL_ACK);
                            slot[1]   = acr_pkg::tx_res(acr_pkg::RPL_CONFIRM);
                            count     = 2'd2;
                            nxt.phase = acr_pkg::PH_CH0;
                        end
                        default:
                        begin
                            count = 2'd0;
                        end
                    endcase
                end
            end
        endcase
    end

    // The channel fields report the state after this item.
    always_comb
    begin
        burst.slot       = slot;
        burst.count      = count;
        burst.channel    = nxt.channel;
        burst.channel_ok = nxt.channel_ok;
    end

endmodule

`default_nettype wire

FILE: tb/sv/adapter_command_responder_top_test.sv
// Self-checking testbench for the adapter command responder: directed and random link bytes.

// One reply item with every field that the block presents per result.
typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        request_valid;
    logic [31:0] request_word;
    logic [15:0] channel_code;
    logic        channel_ok;
    logic        last;
} reply_t;

// Tracks the responder's protocol state and holds the replies still owed by the block.
class reply_board;
    reply_t           pending[$];
    reply_t           burst[$];
    int               errors;
    acr_pkg::phase_t  ph;
    logic [15:0]      chan;
    logic             chan_ok;
    logic [31:0]      acc;

    function new();
        errors  = 0;
        ph      = acr_pkg::PH_IDLE;
        chan    = 16'h0000;
        chan_ok = 1'b1;
        acc     = 32'h0000_0000;
    endfunction

    function reply_t link_byte(input logic [7:0] b);
        reply_t r;
        r               = '0;
        r.tx_valid      = 1'b1;
        r.tx_byte       = b;
        return r;
    endfunction

    // Advances the protocol state by one accepted item and queues the replies it causes.
    function void note_item(input logic [7:0] b, input logic err);
        reply_t r;
        burst.delete();
        case (ph)
            acr_pkg::PH_CH0:
            begin
                if (err)
                begin
                    chan    = 16'h0000;
                    chan_ok = 1'b0;
                    ph      = acr_pkg::PH_IDLE;
                end
                else
                begin
                    chan = {8'h00, b};
                    ph   = acr_pkg::PH_CH1;
                end
            end
            acr_pkg::PH_CH1:
            begin
                if (err)
                begin
                    chan    = 16'h0000;
                    chan_ok = 1'b0;
                end
                else
                begin
                    chan    = chan | {b, 8'h00};
                    chan_ok = 1'b1;
                    burst.push_back(link_byte(acr_pkg::RPL_FINISHED));
                end
                ph = acr_pkg::PH_IDLE;
            end
            acr_pkg::PH_RQ0, acr_pkg::PH_RQ1, acr_pkg::PH_RQ2, acr_pkg::PH_RQ3:
            begin
                if (err)
                begin
                    acc = 32'h0000_0000;
                    ph  = acr_pkg::PH_IDLE;
                end
                else
                begin
                    case (ph)
                        acr_pkg::PH_RQ0:
                        begin
                            acc = acc | {24'h0, b};
                            ph  = acr_pkg::PH_RQ1;
                        end
                        acr_pkg::PH_RQ1:
                        begin
                            acc = acc | {16'h0, b, 8'h0};
                            ph  = acr_pkg::PH_RQ2;
                        end
                        acr_pkg::PH_RQ2:
                        begin
                            acc = acc | {8'h0, b, 16'h0};
                            ph  = acr_pkg::PH_RQ3;
                        end
                        default:
                        begin
                            acc = acc | {b, 24'h0};
                            burst.push_back(link_byte(acr_pkg::RPL_FINISHED));
                            r               = '0;
                            r.request_valid = 1'b1;
                            r.request_word  = acc;
                            burst.push_back(r);
                            acc = 32'h0000_0000;
                            ph  = acr_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                // Idle: a command byte answers at once; errors and unknown bytes are ignored.
                ph = acr_pkg::PH_IDLE;
                if (!err)
                begin
                    case (b)
                        acr_pkg::CMD_STATUS:
                        begin
                            burst.push_back(link_byte(chan_ok ? acr_pkg::RPL_CHAN_OK
                                                              : acr_pkg::RPL_NO_CHAN));
                            burst.push_back(link_byte(acr_pkg::RPL_ACK));
                            burst.push_back(link_byte(acr_pkg::RPL_DONE));
                        end
                        acr_pkg::CMD_PING:
                            burst.push_back(link_byte(acr_pkg::RPL_FINISHED));
                        acr_pkg::CMD_INIT:
                        begin
                            burst.push_back(link_byte(acr_pkg::RPL_ACK));
                            burst.push_back(link_byte(acr_pkg::RPL_DONE));
                        end
                        acr_pkg::CMD_SETUP_A, acr_pkg::CMD_SETUP_B:
                        begin
                            burst.push_back(link_byte(acr_pkg::RPL_ACK));
                            burst.push_back(link_byte(acr_pkg::RPL_CONFIRM));
                        end
                        acr_pkg::CMD_START:
                        begin
                            burst.push_back(link_byte(acr_pkg::RPL_ACK));
                            burst.push_back(link_byte(acr_pkg::RPL_CONFIRM));
                            burst.push_back(link_byte(acr_pkg::RPL_FINISHED));
                        end
                        acr_pkg::CMD_PACKET:
                        begin
                            burst.push_back(link_byte(acr_pkg::RPL_ACK));
                            burst.push_back(link_byte(acr_pkg::RPL_CONFIRM));
                            acc = 32'h0000_0000;
                            ph  = acr_pkg::PH_RQ0;
                        end
                        acr_pkg::CMD_CHANNEL:
                        begin
                            burst.push_back(link_byte(acr_pkg::RPL_ACK));
                            burst.push_back(link_byte(acr_pkg::RPL_CONFIRM));
                            ph = acr_pkg::PH_CH0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase

        // Every reply of this item carries the channel state left behind by it.
        for (int i = 0; i < burst.size(); i++)
        begin
            r              = burst[i];
            r.channel_code = chan;
            r.channel_ok   = chan_ok;
            r.last         = (i == burst.size() - 1);
            pending.push_back(r);
        end
    endfunction

    task report(input string msg);
        if (errors < 50)
            $display("mismatch: %s", msg);
        errors++;
    endtask

    task field_check(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s is %h, %h was due", name, got, want));
    endtask

    // Compares one reply from the block with the oldest one owed.
    task check_reply(input reply_t got);
        reply_t want;
        if (pending.size() == 0)
        begin
            report($sformatf("reply %h arrived with none owed", got));
        end
        else
        begin
            want = pending.pop_front();
            field_check("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
            field_check("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
            field_check("request_valid", 32'(got.request_valid), 32'(want.request_valid));
            field_check("request_word", got.request_word, want.request_word);
            field_check("channel_code", 32'(got.channel_code), 32'(want.channel_code));
            field_check("channel_ok", 32'(got.channel_ok), 32'(want.channel_ok));
            field_check("last", 32'(got.last), 32'(want.last));
        end
    endtask
endclass

module adapter_command_responder_top_test;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte       = 8'h00;
    logic        rx_error      = 1'b0;
    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        request_valid;
    logic [31:0] request_word;
    logic [15:0] channel_code;
    logic        channel_ok;
    logic        last;

    // Set during a stretch of the run in which neither side idles.
    bit          quiet         = 1'b0;
    reply_board  board;

    adapter_command_responder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .rx_error      (rx_error),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tx_valid      (tx_valid),
        .tx_byte       (tx_byte),
        .request_valid (request_valid),
        .request_word  (request_word),
        .channel_code  (channel_code),
        .channel_ok    (channel_ok),
        .last          (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // The reply side stalls now and then.
    always @(negedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < 6);
    end

    // Every reply taken by the link is checked against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_reply({tx_valid, tx_byte, request_valid, request_word,
                               channel_code, channel_ok, last});
    end

    // Offers one item, with an occasional gap first, and returns at the falling edge
    // after it has been taken.
    task automatic send_item(input logic [7:0] b, input logic err);
        while (!quiet && ($urandom_range(99) < 6))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        rx_error <= err;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_item(b, err);
        @(negedge clk);
    endtask

    // Holds the link quiet until every reply owed has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    // One random command sequence; n counts the items that it sends.
    task automatic random_sequence(output int n);
        int pick;
        int k;
        pick = $urandom_range(99);
        n    = 0;
        if (pick < 14)
        begin
            send_item(acr_pkg::CMD_STATUS, 1'b0);
            n = 1;
        end
        else if (pick < 32)
        begin
            case ($urandom_range(4))
                0:       send_item(acr_pkg::CMD_PING, 1'b0);
                1:       send_item(acr_pkg::CMD_INIT, 1'b0);
                2:       send_item(acr_pkg::CMD_SETUP_A, 1'b0);
                3:       send_item(acr_pkg::CMD_SETUP_B, 1'b0);
                default: send_item(acr_pkg::CMD_START, 1'b0);
            endcase
            n = 1;
        end
        else if (pick < 52)
        begin
            send_item(acr_pkg::CMD_CHANNEL, 1'b0);
            send_item(8'($urandom), 1'b0);
            send_item(8'($urandom), 1'b0);
            n = 3;
        end
        else if (pick < 74)
        begin
            send_item(acr_pkg::CMD_PACKET, 1'b0);
            for (int i = 0; i < 4; i++)
                send_item(8'($urandom), 1'b0);
            n = 5;
        end
        else if (pick < 88)
        begin
            // A sequence cut short by a read error.
            if ($urandom_range(1) == 0)
            begin
                send_item(acr_pkg::CMD_CHANNEL, 1'b0);
                k = $urandom_range(1);
            end
            else
            begin
                send_item(acr_pkg::CMD_PACKET, 1'b0);
                k = $urandom_range(3);
            end
            for (int i = 0; i < k; i++)
                send_item(8'($urandom), 1'b0);
            send_item(8'($urandom), 1'b1);
            n = k + 2;
        end
        else
        begin
            send_item(8'($urandom), $urandom_range(99) < 30);
            n = 1;
        end
    endtask

    initial
    begin
        int counted;
        int n;

        board = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Every command that takes no further bytes, from idle, with the valid flag set as after reset.
        send_item(acr_pkg::CMD_STATUS, 1'b0);
        send_item(acr_pkg::CMD_PING, 1'b0);
        send_item(acr_pkg::CMD_INIT, 1'b0);
        send_item(acr_pkg::CMD_SETUP_A, 1'b0);
        send_item(acr_pkg::CMD_SETUP_B, 1'b0);
        send_item(acr_pkg::CMD_START, 1'b0);
        // Unknown bytes and an error in idle give nothing.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(acr_pkg::CMD_STATUS, 1'b1);
        // A complete channel change, then status.
        send_item(acr_pkg::CMD_CHANNEL, 1'b0);
        send_item(8'h34, 1'b0);
        send_item(8'h12, 1'b0);
        send_item(acr_pkg::CMD_STATUS, 1'b0);
        // Error on the low byte clears the channel; status then reports no channel.
        send_item(acr_pkg::CMD_CHANNEL, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(acr_pkg::CMD_STATUS, 1'b0);
        // Error on the high byte after a low byte.
        send_item(acr_pkg::CMD_CHANNEL, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);
        // A full packet request, one broken part-way, and one of all ones.
        send_item(acr_pkg::CMD_PACKET, 1'b0);
        send_item(8'h78, 1'b0);
        send_item(8'h56, 1'b0);
        send_item(8'h34, 1'b0);
        send_item(8'h12, 1'b0);
        send_item(acr_pkg::CMD_PACKET, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hA5, 1'b1);
        send_item(acr_pkg::CMD_PACKET, 1'b0);
        for (int i = 0; i < 4; i++)
            send_item(8'hFF, 1'b0);
        wait_drained();

        // Random part, mostly well-formed sequences with random content.
        counted = 0;
        while (counted < 320)
        begin
            quiet = (counted >= 110) && (counted < 210);
            random_sequence(n);
            counted += n;
            if ($urandom_range(99) < 2)
                wait_drained();
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
sv/acr_pkg.sv
sv/acr_decode.sv
sv/adapter_command_responder_top.sv
tb/sv/adapter_command_responder_top_test.sv
